// ===== sv/sfws_pkg.sv =====
// Shared types, constants and tables for the FIR and window statistics block.
// No dependencies.
package sfws_pkg;

  localparam int unsigned Taps      = 101;
  localparam int unsigned RomHalf   = 51;
  localparam int unsigned Window    = 16;
  localparam int unsigned TapW      = 7;
  localparam int unsigned WinW      = 4;
  localparam int unsigned FillW     = 5;

  localparam logic [31:0] GainReset   = 32'd216252;
  localparam logic [22:0] OffsetReset = 23'd81920;

  localparam logic [0:0] RegGain   = 1'b0;
  localparam logic [0:0] RegOffset = 1'b1;
  localparam logic [0:0] RegLast   = 1'b1;

  localparam logic signed [23:0] VMax = 24'sh7FFFFF;
  localparam logic signed [23:0] VMin = -24'sh800000;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic       load;       // take the sample, compute voltage
    logic       vol_done;   // voltage pipeline settled, update window
    logic       mac_clr;
    logic       mac_en;
    logic [TapW-1:0] tap;
    logic       fir_done;
    logic       stat_go;    // start variance/root units
    logic       out_load;
  } sfws_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
  } sfws_sts_t;

  function automatic logic signed [23:0] coef_at(input logic [TapW-1:0] k);
    logic [TapW-1:0] j;
    logic signed [23:0] c;
    begin
      j = (k < TapW'(RomHalf)) ? k : TapW'(Taps - 1) - k;
      case (j)
        7'd0: c = 0;        7'd1: c = 48;      7'd2: c = 197;     7'd3: c = 455;
        7'd4: c = 831;      7'd5: c = 1337;    7'd6: c = 1986;    7'd7: c = 2794;
        7'd8: c = 3776;     7'd9: c = 4950;    7'd10: c = 6335;   7'd11: c = 7950;
        7'd12: c = 9815;    7'd13: c = 11949;  7'd14: c = 14372;  7'd15: c = 17101;
        7'd16: c = 20155;   7'd17: c = 23548;  7'd18: c = 27293;  7'd19: c = 31399;
        7'd20: c = 35874;   7'd21: c = 40719;  7'd22: c = 45934;  7'd23: c = 51514;
        7'd24: c = 57447;   7'd25: c = 63719;  7'd26: c = 70308;  7'd27: c = 77191;
        7'd28: c = 84337;   7'd29: c = 91711;  7'd30: c = 99270;  7'd31: c = 106974;
        7'd32: c = 114773;  7'd33: c = 122615; 7'd34: c = 130444; 7'd35: c = 138205;
        7'd36: c = 145838;  7'd37: c = 153282; 7'd38: c = 160477; 7'd39: c = 167362;
        7'd40: c = 173880;  7'd41: c = 179972; 7'd42: c = 185586; 7'd43: c = 190668;
        7'd44: c = 195175;  7'd45: c = 199062; 7'd46: c = 202294; 7'd47: c = 204841;
        7'd48: c = 206677;  7'd49: c = 207786; 7'd50: c = 208157;
        default: c = 0;
      endcase
      coef_at = c;
    end
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [47:0] x);
    if (x > 48'(VMax)) sat24 = VMax;
    else if (x < 48'(VMin)) sat24 = VMin;
    else sat24 = x[23:0];
  endfunction

endpackage

// ===== sv/sfws_if.sv =====
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on nothing.
interface sfws_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] adc_sample;
  modport source(output valid, output adc_sample, input ready);
  modport sink(input valid, input adc_sample, output ready);
endinterface

interface sfws_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] voltage;
  logic signed [23:0] filtered;
  logic signed [23:0] window_mean;
  logic [31:0]        window_variance;
  logic [22:0]        window_std;
  logic [22:0]        window_rms;
  logic               window_full;
  modport source(output valid, output voltage, output filtered, output window_mean,
                 output window_variance, output window_std, output window_rms,
                 output window_full, input ready);
  modport sink(input valid, input voltage, input filtered, input window_mean,
               input window_variance, input window_std, input window_rms,
               input window_full, output ready);
endinterface

// ===== sv/sfws_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// Depends on nothing.
module sfws_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem_r [Depth];
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end
endmodule

// ===== sv/sfws_ctrl.sv =====
// Sequencer for the FIR and window statistics block.
// Depends on sfws_pkg.
module sfws_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_valid,
  input  logic                out_ready,
  input  sfws_pkg::sfws_sts_t sts,
  output sfws_pkg::sfws_cmd_t cmd
);
  import sfws_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StVol  = 3'd1;
  localparam logic [2:0] StMac  = 3'd2;
  localparam logic [2:0] StTail = 3'd3;
  localparam logic [2:0] StStat = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]      state_r, state_nxt;
  logic [TapW-1:0] tap_r, tap_nxt;
  logic [1:0]      cnt_r, cnt_nxt;

  assign in_ready = (state_r == StIdle);

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.tap   = tap_r;
    case (state_r)
      StIdle: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = 2'd0;
          state_nxt = StVol;
        end
      end
      StVol: begin
        // wait for the voltage pipeline to settle
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd1) begin
          cmd.vol_done = 1'b1;
          cmd.mac_clr  = 1'b1;
          cmd.stat_go  = 1'b1;
          tap_nxt      = '0;
          state_nxt    = StMac;
        end
      end
      StMac: begin
        // address tap_r issued; the product reaches the MAC after the RAM read and mul_r registers
        cmd.mac_en = 1'b1;
        tap_nxt    = tap_r + 1'b1;
        if (tap_r == TapW'(Taps - 1)) begin
          cnt_nxt   = 2'd0;
          state_nxt = StTail;
        end
      end
      StTail: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd2) begin
          cmd.fir_done = 1'b1;
          state_nxt    = StStat;
        end
      end
      StStat: begin
        if (!sts.div_busy && !sts.sqrt_busy) begin
          if (!out_valid || out_ready) begin
            cmd.out_load = 1'b1;
            state_nxt    = StOut;
          end
        end
      end
      StOut: state_nxt = StIdle;
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      tap_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == StIdle) else $error("load outside idle");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> !cmd.out_load) else $error("double result");
  a_mac_tap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mac_en |-> tap_r <= TapW'(Taps - 1)) else $error("tap out of range");
endmodule

// ===== sv/sfws_dp.sv =====
// Datapath: voltage scaling, FIR delay RAM with shared MAC, window, divider, root.
// Depends on sfws_pkg and sfws_ram.
module sfws_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         adc_sample,
  input  logic [31:0]         gain,
  input  logic [22:0]         offset,
  input  sfws_pkg::sfws_cmd_t cmd,
  output sfws_pkg::sfws_sts_t sts,
  output logic signed [23:0]  voltage,
  output logic signed [23:0]  filtered,
  output logic signed [23:0]  window_mean,
  output logic [31:0]         window_variance,
  output logic [22:0]         window_std,
  output logic [22:0]         window_rms,
  output logic                window_full
);
  import sfws_pkg::*;

  // ---- voltage
  logic [15:0]        samp_r;
  logic [47:0]        prod_r;
  logic signed [23:0] v_r;
  logic signed [49:0] x_s;
  logic signed [49:0] y_s;

  always_ff @(posedge clk) begin
    if (cmd.load) samp_r <= adc_sample;
    prod_r <= samp_r * gain;
  end
  assign x_s = $signed({2'b00, prod_r}) - $signed({11'd0, offset, 16'd0});
  assign y_s = (x_s + 50'sd4096) >>> 13;  // floor shift equals round-half-up here
  always_ff @(posedge clk) if (cmd.vol_done) v_r <= sat24(y_s[47:0]);

  // ---- FIR delay line: circular RAM, head points at newest
  logic [TapW-1:0] head_r;
  logic [TapW-1:0] raddr;
  logic [TapW:0]   sum_a;
  logic [23:0]     rdata;
  logic [TapW-1:0] tap_d1_r;
  logic            en_d1_r, en_d2_r;
  logic signed [47:0] mul_r;
  logic signed [55:0] acc_r;
  logic            wr_fir;

  // head advances on each voltage; write it at the new head
  logic [TapW-1:0] head_nxt;
  assign head_nxt = (head_r == '0) ? TapW'(Taps - 1) : head_r - 1'b1;
  assign wr_fir   = cmd.vol_done;
  assign sum_a    = {1'b0, head_r} + {1'b0, cmd.tap};
  assign raddr    = (sum_a >= (TapW+1)'(Taps)) ? TapW'(sum_a - (TapW+1)'(Taps))
                                               : sum_a[TapW-1:0];

  logic [TapW-1:0] clr_r;
  logic            clr_busy_r;
  logic            ram_we;
  logic [TapW-1:0] ram_wa;
  logic [23:0]     ram_wd;
  assign ram_we = clr_busy_r | wr_fir;
  assign ram_wa = clr_busy_r ? clr_r : head_nxt;
  assign ram_wd = clr_busy_r ? 24'd0 : sat24(y_s[47:0]);

  sfws_ram #(.Width(24), .Depth(128)) u_fir_ram (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(raddr), .rdata(rdata));

  // bypass the just-written newest sample on tap 0 read collision is avoided:
  // the write happens at vol_done, the first read in the cycle after.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      clr_r      <= '0;
      clr_busy_r <= 1'b1;
      en_d1_r    <= 1'b0;
      en_d2_r    <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == TapW'(Taps - 1)) clr_busy_r <= 1'b0;
      end
      if (wr_fir) head_r <= head_nxt;
      en_d1_r <= cmd.mac_en;
      en_d2_r <= en_d1_r;
    end
  end
  always_ff @(posedge clk) begin
    tap_d1_r <= cmd.tap;
    mul_r    <= coef_at(tap_d1_r) * $signed(rdata);
    if (cmd.mac_clr) acc_r <= '0;
    else if (en_d2_r) acc_r <= acc_r + 56'(mul_r);
  end

  logic signed [55:0] facc;
  assign facc = (acc_r + 56'sd4194304) >>> 23;
  logic signed [23:0] filt_r;
  always_ff @(posedge clk) if (cmd.fir_done) filt_r <= sat24(facc[47:0]);

  // ---- window
  logic signed [23:0] win_r [Window];
  logic signed [27:0] sum_r;
  logic [51:0]        sq_r;
  logic [FillW-1:0]   fill_r;
  logic signed [47:0] vsq, osq;
  logic signed [23:0] vnew;
  assign vnew = sat24(y_s[47:0]);
  assign vsq  = vnew * vnew;
  assign osq  = win_r[0] * win_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Window; i++) win_r[i] <= '0;
      sum_r  <= '0;
      sq_r   <= '0;
      fill_r <= '0;
    end else if (cmd.vol_done) begin
      for (int i = 0; i < Window - 1; i++) win_r[i] <= win_r[i+1];
      win_r[Window-1] <= vnew;
      sum_r <= sum_r + 28'(vnew) - 28'(win_r[0]);
      sq_r  <= sq_r + 52'(vsq) - 52'(osq);
      if (fill_r < FillW'(Window)) fill_r <= fill_r + 1'b1;
    end
  end

  // mean: floor((2s+W)/2W) = (s + W/2) >> log2 W
  logic signed [27:0] mean_s;
  assign mean_s = (sum_r + 28'sd8) >>> WinW;

  // ---- variance: num = W*sq - s^2; registered square first
  logic [55:0] s2_r, num_r;
  logic [27:0] sabs;
  logic [55:0] a_w;
  logic        st_d1_r, st_d2_r, st_d3_r;
  assign sabs = sum_r[27] ? 28'(-sum_r) : sum_r;
  assign a_w  = {sq_r, 4'd0};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_d1_r <= 1'b0;
      st_d2_r <= 1'b0;
      st_d3_r <= 1'b0;
    end else begin
      st_d1_r <= cmd.stat_go;
      st_d2_r <= st_d1_r;
      st_d3_r <= st_d2_r;
    end
    s2_r  <= sabs * sabs;
    num_r <= (a_w > s2_r) ? a_w - s2_r : '0;
  end

  // divide by 240 as (num/16)/15; with y = 16h + l, y/15 = h + (h + l)/15,
  // so fold the top nibbles down until y drops below 16
  logic [55:0] dq_r;
  logic [55:0] dy_r;
  logic        dbusy_r;
  logic [55:0] dhi;
  assign dhi = dy_r >> 4;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (st_d3_r) begin
      dbusy_r <= 1'b1;
      dq_r    <= '0;
      dy_r    <= num_r >> 4;
    end else if (dbusy_r) begin
      if (dy_r >= 56'd16) begin
        dq_r <= dq_r + dhi;
        dy_r <= dhi + {52'd0, dy_r[3:0]};
      end else begin
        if (dy_r[3:0] == 4'hF) dq_r <= dq_r + 56'd1;
        dbusy_r <= 1'b0;
      end
    end
  end
  // var = floor((num + 240*32768)/(240*65536)) = (q + (r>=120? ... )) : use
  // (num + 240*2^15) / (240*2^16) = floor((q*240 + r + 240*2^15)/(240*2^16))
  // = floor((q + 2^15 + (r)/240)/2^16) = (q + 2^15) >> 16 since r < 240
  logic [56:0] var_w;
  assign var_w = {1'b0, dq_r} + 57'd32768;
  logic [31:0] var_sat;
  assign var_sat = (|var_w[56:48]) ? 32'hFFFFFFFF : var_w[47:16];

  // ---- shared bit-pair root: first var32 (std), then sq/W (rms)
  logic [55:0] rx_r, rr_r, rb_r;
  logic        rbusy_r, rsel_r;
  logic [22:0] std_r, rms_r;
  logic        dbusy_d_r;
  logic [55:0] rsum;
  assign rsum = rr_r + rb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rbusy_r   <= 1'b0;
      rsel_r    <= 1'b0;
      dbusy_d_r <= 1'b0;
    end else begin
      dbusy_d_r <= dbusy_r;
      if (dbusy_d_r && !dbusy_r) begin
        rbusy_r <= 1'b1;
        rsel_r  <= 1'b0;
        rx_r    <= dq_r;
        rr_r    <= '0;
        rb_r    <= 56'd1 << 54;
      end else if (rbusy_r) begin
        if (rb_r == '0) begin
          if (!rsel_r) begin
            std_r  <= (|rr_r[55:23]) ? 23'h7FFFFF : rr_r[22:0];
            rsel_r <= 1'b1;
            rx_r   <= 56'(sq_r >> WinW);
            rr_r   <= '0;
            rb_r   <= 56'd1 << 54;
          end else begin
            rms_r   <= (|rr_r[55:23]) ? 23'h7FFFFF : rr_r[22:0];
            rbusy_r <= 1'b0;
          end
        end else begin
          if (rx_r >= rsum) begin
            rx_r <= rx_r - rsum;
            rr_r <= (rr_r >> 1) + rb_r;
          end else begin
            rr_r <= rr_r >> 1;
          end
          rb_r <= rb_r >> 2;
        end
      end
    end
  end

  assign sts.div_busy  = dbusy_r | st_d1_r | st_d2_r | st_d3_r | cmd.stat_go;
  assign sts.sqrt_busy = rbusy_r | (dbusy_d_r & ~dbusy_r) | (dbusy_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      voltage         <= v_r;
      filtered        <= filt_r;
      window_mean     <= sat24(48'(mean_s));
      window_variance <= var_sat;
      window_std      <= std_r;
      window_rms      <= rms_r;
      window_full     <= (fill_r >= FillW'(Window));
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FillW'(Window)) else $error("fill count overrun");
  a_no_clr_use: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.vol_done |-> !clr_busy_r) else $error("sample during clear");
  a_div_root: assert property (@(posedge clk) disable iff (!rst_n)
    !(dbusy_r && rbusy_r)) else $error("root started before divide done");
endmodule

// ===== sv/sample_fir_and_window_stats.sv =====
// Top level of the sample scaler, low-pass FIR and window statistics block.
// Depends on sfws_pkg, sfws_if, sfws_ctrl, sfws_dp.
//
// Each item is one 16-bit ADC sample; each yields one result item with the
// scaled voltage, the 101-tap FIR output and the mean, variance, std and RMS
// over the last 16 voltages. One item is in flight at a time. The result passes
// scaling, the shared MAC walking the delay-line RAM one tap a cycle, the drain
// of the MAC pipeline and the result register. The divide by 240 (folding four
// bits a cycle) and the two square roots on one shared root unit run while the
// MAC walks and add nothing. The next item is accepted only after the result is
// loaded; a result left waiting holds the sequencer, and so the input, until it
// is taken. After reset a clearing pass zeros the delay-line RAM, during which
// no item is taken. Write configuration only with no item in flight.
module sample_fir_and_window_stats (
  input  logic              clk,
  input  logic              rst_n,
  sfws_in_if.sink           in_ch,
  sfws_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);
  import sfws_pkg::*;

  logic [31:0] gain_r;
  logic [22:0] offset_r;
  logic        out_valid_r;
  sfws_cmd_t   cmd;
  sfws_sts_t   sts;
  logic        ctrl_ready;
  logic        clr_wait_r;
  logic [TapW-1:0] clr_cnt_r;

  // hold the registers; writes to unknown indexes fall away naturally
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GainReset;
      offset_r <= OffsetReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegGain:   gain_r   <= cfg_wdata;
        RegOffset: offset_r <= cfg_wdata[22:0];
        default:   ;
      endcase
    end
  end

  // hide the input from the sequencer while the clear runs
  sfws_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid & ~clr_wait_r), .in_ready(ctrl_ready),
    .out_valid(out_valid_r), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd));

  sfws_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .adc_sample(in_ch.adc_sample), .gain(gain_r), .offset(offset_r),
    .cmd(cmd), .sts(sts),
    .voltage(out_ch.voltage), .filtered(out_ch.filtered),
    .window_mean(out_ch.window_mean), .window_variance(out_ch.window_variance),
    .window_std(out_ch.window_std), .window_rms(out_ch.window_rms),
    .window_full(out_ch.window_full));

  // hold back items while the delay-line clear runs after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_wait_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_wait_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == TapW'(Taps - 1)) clr_wait_r <= 1'b0;
    end
  end
  assign in_ch.ready = ctrl_ready & ~clr_wait_r;

  // result register: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end
  assign out_ch.valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ch.ready)) else $error("result lost");
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> cmd.load) else $error("accept without load");
  a_ready_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_wait_r |-> !in_ch.ready) else $error("ready during clear");
endmodule

// ===== dv/testbench.sv =====
// Testbench for sample_fir_and_window_stats: a directed table, then random samples under
// several gain and offset settings, checked field by field against an in-bench predictor.
// Depends on sfws_pkg, sfws_if and the block's RTL.
`timescale 1ns / 100ps

module testbench;
  import sfws_pkg::*;

  // ---------------------------------------------------------------- types and constants
  typedef struct packed {
    logic signed [23:0] voltage;
    logic signed [23:0] filtered;
    logic signed [23:0] window_mean;
    logic [31:0]        window_variance;
    logic [22:0]        window_std;
    logic [22:0]        window_rms;
    logic               window_full;
  } stats_t;

  typedef enum logic { RowCfg, RowSample } row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [0:0]         index;
    logic [31:0]        value;     // register data, or the sample in the low 16 bits
    bit                 typed_v;   // voltage below is typed in by hand
    logic signed [23:0] typed_volt;
  } dir_row_t;

  localparam int unsigned NumTaps   = 101;
  localparam int unsigned WinLen    = 16;
  localparam int unsigned Settle    = 300;    // cycles past the last result before a write
  localparam int unsigned HoldOff   = 3000;   // receiver stall length
  localparam int unsigned IdleLimit = 20000;  // watchdog limit in cycles with no item moving
  localparam int unsigned PhaseLen  = 310;
  localparam int unsigned NumPhases = 6;
  localparam longint      Q716Max   = 64'sd8388607;
  localparam longint      Q716Min   = -64'sd8388608;

  // low-pass ROM, first half of the symmetric taps in Q1.23
  localparam int CoefHalf [51] = '{
    0, 48, 197, 455, 831, 1337, 1986, 2794,
    3776, 4950, 6335, 7950, 9815, 11949, 14372, 17101,
    20155, 23548, 27293, 31399, 35874, 40719, 45934, 51514,
    57447, 63719, 70308, 77191, 84337, 91711, 99270, 106974,
    114773, 122615, 130444, 138205, 145838, 153282, 160477, 167362,
    173880, 179972, 185586, 190668, 195175, 199062, 202294, 204841,
    206677, 207786, 208157
  };

  // ---------------------------------------------------------------- clock, reset, DUT
  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_wdata;

  sfws_in_if  in_ch ();
  sfws_out_if out_ch ();

  sample_fir_and_window_stats dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor state
  logic [31:0]        gain_q032;
  logic [22:0]        offset_q716;
  logic signed [23:0] taps_line [NumTaps];
  logic signed [23:0] win_vals [WinLen];
  longint             win_sum;
  longint unsigned    win_sq_sum;
  int unsigned        win_count;

  stats_t expected_stats [$];
  int unsigned mismatches;

  // run control shared by the processes
  bit quiet;       // no idling on either side
  bit hold_req;    // receiver: stall for a long stretch
  bit hold_done;

  function automatic logic signed [23:0] clamp_q716(input longint x);
    if (x > Q716Max) return 24'sh7FFFFF;
    if (x < Q716Min) return -24'sh800000;
    return x[23:0];
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Advance the predictor by one sample and return the stats it should produce.
  function automatic stats_t predict_stats(input logic [15:0] sample);
    stats_t          s;
    longint          x;
    longint          acc;
    longint          c;
    longint          v;
    longint          old;
    longint unsigned mag;
    longint unsigned sq;
    longint unsigned num;
    longint unsigned var32;
    longint unsigned varr;
    longint unsigned root;
    int              k;
    // scale: product in Q.32 minus offset, round half up to Q.16 after the x8 gain
    x = longint'(64'(sample) * 64'(gain_q032)) - (longint'(offset_q716) <<< 16);
    s.voltage = clamp_q716((x + 4096) >>> 13);
    v = longint'(s.voltage);
    // FIR over the delay line, newest at position 0
    for (k = NumTaps - 1; k > 0; k--) taps_line[k] = taps_line[k - 1];
    taps_line[0] = s.voltage;
    acc = 0;
    for (k = 0; k < NumTaps; k++) begin
      c = (k < 51) ? CoefHalf[k] : CoefHalf[NumTaps - 1 - k];
      acc = acc + c * longint'(taps_line[k]);
    end
    s.filtered = clamp_q716((acc + (64'sd1 <<< 22)) >>> 23);
    // slide the window, drop the oldest
    old = longint'(win_vals[0]);
    for (k = 0; k < WinLen - 1; k++) win_vals[k] = win_vals[k + 1];
    win_vals[WinLen - 1] = s.voltage;
    win_sum = win_sum + v - old;
    win_sq_sum = win_sq_sum + longint'(v * v) - longint'(old * old);
    if (win_count < WinLen) win_count++;
    // mean, half up; the divisor stays WinLen on a partly filled window
    s.window_mean = clamp_q716((win_sum + 8) >>> 4);
    mag = (win_sum < 0) ? -win_sum : win_sum;
    sq = mag * mag;
    num = (64'(WinLen) * win_sq_sum > sq) ? 64'(WinLen) * win_sq_sum - sq : 64'd0;
    var32 = num / 64'd240;
    varr = (num + 64'd240 * 64'd32768) / (64'd240 * 64'd65536);
    s.window_variance = (varr > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : varr[31:0];
    root = floor_sqrt(var32);
    s.window_std = (root > 64'd8388607) ? 23'h7FFFFF : root[22:0];
    root = floor_sqrt(win_sq_sum / 64'(WinLen));
    s.window_rms = (root > 64'd8388607) ? 23'h7FFFFF : root[22:0];
    s.window_full = (win_count >= WinLen);
    return s;
  endfunction

  task automatic report(input string field, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- sender
  // Offer one sample and hold it until taken. Valid stays high on return so a
  // back-to-back item needs no lowering.
  task automatic send_sample(input logic [15:0] sample, input bit typed_v,
                             input logic signed [23:0] typed_volt);
    stats_t s;
    in_ch.valid      <= 1'b1;
    in_ch.adc_sample <= sample;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    s = predict_stats(sample);
    if (typed_v) s.voltage = typed_volt;
    expected_stats.push_back(s);
  endtask

  // Random gap after an item; drop valid only if a gap is taken.
  task automatic sender_gap();
    if (!quiet && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Wait until every expected result has come, then let the block go idle.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] index, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == RegGain) gain_q032 = value;
    else offset_q716 = value[22:0];
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'(32768 + $urandom_range(0, 512) - 256);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] pick_gain(input int phase);
    case (phase)
      0:       return GainReset;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd0;
      3:       return 32'($urandom_range(1, 1 << 20));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_offset(input int phase);
    case (phase)
      0:       return 32'(OffsetReset);
      1:       return 32'd0;
      2:       return 32'h007F_FFFF;
      default: return $urandom();   // upper bits must be ignored
    endcase
  endfunction

  // ---------------------------------------------------------------- main sequence
  dir_row_t dir_rows [$];

  initial begin
    int unsigned i;
    int          phase;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.adc_sample <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= RegGain;
    cfg_wdata        <= '0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    mismatches = 0;
    gain_q032   = GainReset;
    offset_q716 = OffsetReset;
    foreach (taps_line[k]) taps_line[k] = '0;
    foreach (win_vals[k]) win_vals[k] = '0;
    win_sum    = 0;
    win_sq_sum = 0;
    win_count  = 0;

    // directed table: zero gain, saturation both ways, masking, then defaults
    dir_rows.push_back('{RowCfg,    RegGain,   32'd0,          1'b0, 24'sd0});
    dir_rows.push_back('{RowSample, RegGain,   32'h1234,       1'b1, 24'sd0 - 24'sd655360});
    dir_rows.push_back('{RowSample, RegGain,   32'hFFFF,       1'b1, 24'sd0 - 24'sd655360});
    dir_rows.push_back('{RowCfg,    RegOffset, 32'd0,          1'b0, 24'sd0});
    dir_rows.push_back('{RowSample, RegGain,   32'hFFFF,       1'b1, 24'sd0});
    dir_rows.push_back('{RowCfg,    RegGain,   32'hFFFF_FFFF,  1'b0, 24'sd0});
    dir_rows.push_back('{RowSample, RegGain,   32'hFFFF,       1'b1, 24'sh7FFFFF});
    dir_rows.push_back('{RowSample, RegGain,   32'h0000,       1'b1, 24'sd0});
    dir_rows.push_back('{RowSample, RegGain,   32'h8000,       1'b0, 24'sd0});
    dir_rows.push_back('{RowCfg,    RegOffset, 32'h007F_FFFF,  1'b0, 24'sd0});
    dir_rows.push_back('{RowSample, RegGain,   32'h0000,       1'b1, -24'sh800000});
    dir_rows.push_back('{RowCfg,    RegGain,   32'h0001_0000,  1'b0, 24'sd0});
    dir_rows.push_back('{RowCfg,    RegOffset, 32'hFF80_0000,  1'b0, 24'sd0});
    dir_rows.push_back('{RowSample, RegGain,   32'hFFFF,       1'b1, 24'sd524280});
    dir_rows.push_back('{RowCfg,    RegGain,   GainReset,      1'b0, 24'sd0});
    dir_rows.push_back('{RowCfg,    RegOffset, 32'hFF80_0000 | 32'(OffsetReset), 1'b0, 24'sd0});
    dir_rows.push_back('{RowSample, RegGain,   32'h0000,       1'b0, 24'sd0});
    dir_rows.push_back('{RowSample, RegGain,   32'h0001,       1'b0, 24'sd0});
    dir_rows.push_back('{RowSample, RegGain,   32'hAAAA,       1'b0, 24'sd0});
    dir_rows.push_back('{RowSample, RegGain,   32'h5555,       1'b0, 24'sd0});
    dir_rows.push_back('{RowSample, RegGain,   32'hFFFF,       1'b0, 24'sd0});
    dir_rows.push_back('{RowSample, RegGain,   32'h7FFF,       1'b0, 24'sd0});
    dir_rows.push_back('{RowSample, RegGain,   32'h8001,       1'b0, 24'sd0});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the table; registers change only with the block drained
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == RowCfg) begin
        drain_block();
        write_reg(dir_rows[r].index, dir_rows[r].value);
      end else begin
        send_sample(dir_rows[r].value[15:0], dir_rows[r].typed_v, dir_rows[r].typed_volt);
        sender_gap();
      end
    end

    // random phases, each under its own gain and offset
    for (phase = 0; phase < NumPhases; phase++) begin
      drain_block();
      write_reg(RegGain, pick_gain(phase));
      write_reg(RegOffset, pick_offset(phase));
      quiet = (phase == 4);
      if (phase == 3) hold_req = 1'b1;   // receiver stalls while items keep coming
      for (i = 0; i < PhaseLen; i++) begin
        send_sample(pick_sample(), 1'b0, 24'sd0);
        if (i == PhaseLen / 2) begin
          // pause the sender until the block is empty
          in_ch.valid <= 1'b0;
          while (expected_stats.size() != 0) @(posedge clk);
        end else begin
          sender_gap();
        end
      end
    end
    quiet = 1'b0;

    drain_block();
    if (expected_stats.size() != 0) report("leftover results", expected_stats.size(), 0);
    if (mismatches == 0) begin
      $display("sample_fir_and_window_stats test passed");
    end else begin
      $display("sample_fir_and_window_stats test failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  initial begin
    stats_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_stats.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = expected_stats.pop_front();
          if (out_ch.voltage !== want.voltage)
            report("voltage", out_ch.voltage, want.voltage);
          if (out_ch.filtered !== want.filtered)
            report("filtered", out_ch.filtered, want.filtered);
          if (out_ch.window_mean !== want.window_mean)
            report("window_mean", out_ch.window_mean, want.window_mean);
          if (out_ch.window_variance !== want.window_variance)
            report("window_variance", out_ch.window_variance, want.window_variance);
          if (out_ch.window_std !== want.window_std)
            report("window_std", out_ch.window_std, want.window_std);
          if (out_ch.window_rms !== want.window_rms)
            report("window_rms", out_ch.window_rms, want.window_rms);
          if (out_ch.window_full !== want.window_full)
            report("window_full", out_ch.window_full, want.window_full);
        end
      end
      if (hold_req && !hold_done) begin
        // stall the output long enough that the input backs up
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldOff) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(99) >= 32);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  int unsigned stuck_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IdleLimit) begin
      $display("TIMEOUT: no item moved for %0d cycles", IdleLimit);
      $display("sample_fir_and_window_stats test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
